[hw/rtl/psbw_pkg.sv]
// ----------------------------------------------------------------------------
// psbw_pkg
// Shared widths, codes, types and saturation helpers for the periodic
// shear boundary wrap block.
// ----------------------------------------------------------------------------
package psbw_pkg;

  // Field widths
  localparam int COORD_WIDTH = 32;
  localparam int BOX_W       = 31;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Wrap pass limit per axis and pass counter width
  localparam int MAX_WRAPS   = 8;
  localparam int WCNT_W      = $clog2(MAX_WRAPS + 1);

  // Internal coordinate width: room for MAX_WRAPS y shifts on top of a coordinate
  localparam int INT_W       = COORD_WIDTH + $clog2(MAX_WRAPS + 2) + 1;

  // Boundary modes
  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHEAR    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_OUTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_INNER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_AZ     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_RAD    = 3'd7;

  // Reset box length: 1.0 in Q16.16
  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(65536);

  // Configuration snapshot seen by the sequencer
  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic [BOX_W-1:0]              box_x;
    logic [BOX_W-1:0]              box_y;
    logic [BOX_W-1:0]              box_z;
    logic signed [COORD_WIDTH-1:0] shift_outer;
    logic signed [COORD_WIDTH-1:0] shift_inner;
    logic signed [COORD_WIDTH-1:0] kick_az;
    logic signed [COORD_WIDTH-1:0] kick_rad;
  } psbw_cfg_t;

  // Request to the shared wrap unit
  typedef struct packed {
    logic signed [INT_W-1:0] coord;
    logic [BOX_W-1:0]        box;
  } psbw_alu_req_t;

  // Response of the shared wrap unit
  typedef struct packed {
    logic                    above;
    logic                    below;
    logic signed [INT_W-1:0] wrapped;
  } psbw_alu_rsp_t;

  // Clamp an internal coordinate to the signed coordinate range
  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [INT_W-1:0] v);
    logic [INT_W-COORD_WIDTH:0] hi;
    hi = v[INT_W-1:COORD_WIDTH-1];
    if ((&hi) || (~|hi)) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[INT_W-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // Saturating add or subtract of two signed coordinates
  function automatic logic [COORD_WIDTH-1:0] sat_addsub(input logic [COORD_WIDTH-1:0] a,
                                                       input logic [COORD_WIDTH-1:0] b,
                                                       input logic sub);
    logic [COORD_WIDTH:0] ae;
    logic [COORD_WIDTH:0] be;
    logic [COORD_WIDTH:0] s;
    ae = {a[COORD_WIDTH-1], a};
    be = {b[COORD_WIDTH-1], b};
    s  = sub ? (ae - be) : (ae + be);
    if (s[COORD_WIDTH] == s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH-1:0];
    end else if (s[COORD_WIDTH]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

[hw/rtl/psbw_if.sv]
// ----------------------------------------------------------------------------
// psbw interfaces
// Valid/ready channels for particles in, wrapped particles out and
// register writes.
// ----------------------------------------------------------------------------
interface psbw_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  pos_x;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  pos_y;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  pos_z;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  vel_x;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  vel_y;
  logic                                     last_in_batch;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, last_in_batch,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, last_in_batch,
                  output ready);
endinterface

interface psbw_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  new_x;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  new_y;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  new_z;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  new_vx;
  logic signed [psbw_pkg::COORD_WIDTH-1:0]  new_vy;
  logic                                     remove_flag;
  logic                                     unsettled_flag;
  logic                                     last_out;

  modport source (output valid, new_x, new_y, new_z, new_vx, new_vy, remove_flag,
                  unsettled_flag, last_out, input ready);
  modport sink   (input valid, new_x, new_y, new_z, new_vx, new_vy, remove_flag,
                  unsettled_flag, last_out, output ready);
endinterface

interface psbw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [psbw_pkg::CFG_IDX_W-1:0]     wr_index;
  logic [psbw_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

[hw/rtl/periodic_shear_boundary_wrap_top.sv]
// Flow: in mode none a particle goes straight to the result register; otherwise
//   x, y and z each pass through the wrap unit first (each axis wraps at most 8 times).
// The input waits until the particle has left for the result register: ready is high
//   only while the sequencer is idle, as it steps x, y and z through the single shared compare/add unit.
// Reset: synchronous active-low rst_n clears the sequencer and the result valid,
//   sets mode none, box lengths 1.0 and all shift and kick registers to zero.
// ----------------------------------------------------------------------------
// periodic_shear_boundary_wrap_top
// Periodic, open and shearing-sheet boundary handling for one particle at a
// time, with register-programmed box size and shear terms.
// ----------------------------------------------------------------------------
module periodic_shear_boundary_wrap_top (
  input  logic        clk,
  input  logic        rst_n,
  psbw_in_if.sink     in_ch,
  psbw_out_if.source  out_ch,
  psbw_cfg_if.sink    cfg_ch
);

  psbw_pkg::psbw_cfg_t     cfg;
  psbw_pkg::psbw_alu_req_t alu_req;
  psbw_pkg::psbw_alu_rsp_t alu_rsp;

  // Configuration registers
  psbw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Shared wrap unit
  psbw_wrap_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Axis sequencer and result register
  psbw_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

endmodule

[hw/rtl/psbw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// psbw_cfg_regs
// Boundary configuration register file; always takes a write.
// ----------------------------------------------------------------------------
module psbw_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  psbw_cfg_if.sink            cfg_ch,
  output psbw_pkg::psbw_cfg_t cfg
);

  psbw_pkg::psbw_cfg_t cfg_r;
  psbw_pkg::psbw_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.wr_index)
        psbw_pkg::REG_MODE:        cfg_nxt.mode        = cfg_ch.wr_data[psbw_pkg::MODE_W-1:0];
        psbw_pkg::REG_BOX_X:       cfg_nxt.box_x       = cfg_ch.wr_data[psbw_pkg::BOX_W-1:0];
        psbw_pkg::REG_BOX_Y:       cfg_nxt.box_y       = cfg_ch.wr_data[psbw_pkg::BOX_W-1:0];
        psbw_pkg::REG_BOX_Z:       cfg_nxt.box_z       = cfg_ch.wr_data[psbw_pkg::BOX_W-1:0];
        psbw_pkg::REG_SHIFT_OUTER: cfg_nxt.shift_outer = cfg_ch.wr_data;
        psbw_pkg::REG_SHIFT_INNER: cfg_nxt.shift_inner = cfg_ch.wr_data;
        psbw_pkg::REG_KICK_AZ:     cfg_nxt.kick_az     = cfg_ch.wr_data;
        psbw_pkg::REG_KICK_RAD:    cfg_nxt.kick_rad    = cfg_ch.wr_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= psbw_pkg::MODE_NONE;
      cfg_r.box_x       <= psbw_pkg::BOX_RESET;
      cfg_r.box_y       <= psbw_pkg::BOX_RESET;
      cfg_r.box_z       <= psbw_pkg::BOX_RESET;
      cfg_r.shift_outer <= '0;
      cfg_r.shift_inner <= '0;
      cfg_r.kick_az     <= '0;
      cfg_r.kick_rad    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/psbw_wrap_alu.sv]
// ----------------------------------------------------------------------------
// psbw_wrap_alu
// Shared compare and add unit: tests 2c against +/-box and forms c -/+ box.
// ----------------------------------------------------------------------------
module psbw_wrap_alu (
  input  psbw_pkg::psbw_alu_req_t req,
  output psbw_pkg::psbw_alu_rsp_t rsp
);

  logic signed [psbw_pkg::INT_W:0]   two_c;
  logic signed [psbw_pkg::INT_W:0]   box_w;
  logic signed [psbw_pkg::INT_W-1:0] box_c;

  // Doubled coordinate and zero-extended box
  assign two_c = {req.coord, 1'b0};
  assign box_w = $signed({{(psbw_pkg::INT_W + 1 - psbw_pkg::BOX_W){1'b0}}, req.box});
  assign box_c = $signed({{(psbw_pkg::INT_W - psbw_pkg::BOX_W){1'b0}}, req.box});

  // Outside test and one wrap step
  assign rsp.above   = two_c > box_w;
  assign rsp.below   = two_c < -box_w;
  assign rsp.wrapped = rsp.above ? (req.coord - box_c) : (req.coord + box_c);

endmodule

[hw/rtl/psbw_seq.sv]
// ----------------------------------------------------------------------------
// psbw_seq
// Sequencer: walks x, y and z through the shared wrap unit one pass per
// cycle, applies shear shifts and kicks, and holds the result register.
// ----------------------------------------------------------------------------
module psbw_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  psbw_pkg::psbw_cfg_t     cfg,
  psbw_in_if.sink                 in_ch,
  psbw_out_if.source              out_ch,
  output psbw_pkg::psbw_alu_req_t alu_req,
  input  psbw_pkg::psbw_alu_rsp_t alu_rsp
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_X    = 3'd1;
  localparam logic [2:0] ST_Y    = 3'd2;
  localparam logic [2:0] ST_Z    = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int IW = psbw_pkg::INT_W;
  localparam int CW = psbw_pkg::COORD_WIDTH;

  logic [2:0]                  state_r, state_nxt;
  logic [psbw_pkg::WCNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [IW-1:0]        x_r, x_nxt;
  logic signed [IW-1:0]        y_r, y_nxt;
  logic signed [IW-1:0]        z_r, z_nxt;
  logic [CW-1:0]               vx_r, vx_nxt;
  logic [CW-1:0]               vy_r, vy_nxt;
  logic                        last_r, last_nxt;
  logic                        rem_r, rem_nxt;
  logic                        uns_r, uns_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [CW-1:0]               ox_r, oy_r, oz_r, ovx_r, ovy_r;
  logic                        orem_r, ouns_r, olast_r;

  logic                        in_fire;
  logic                        out_free;
  logic                        outside;
  logic                        go_next;
  logic                        shear_x;
  logic signed [IW-1:0]        shift_sel;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Operand select for the shared unit
  always_comb begin
    case (state_r)
      ST_Y:    begin alu_req.coord = y_r; alu_req.box = cfg.box_y; end
      ST_Z:    begin alu_req.coord = z_r; alu_req.box = cfg.box_z; end
      default: begin alu_req.coord = x_r; alu_req.box = cfg.box_x; end
    endcase
  end

  assign outside   = alu_rsp.above || alu_rsp.below;
  assign go_next   = (cfg.mode == psbw_pkg::MODE_OPEN) || !outside ||
                     (cnt_r == psbw_pkg::WCNT_W'(psbw_pkg::MAX_WRAPS));
  assign shear_x   = (state_r == ST_X) && (cfg.mode == psbw_pkg::MODE_SHEAR);
  assign shift_sel = alu_rsp.above ? IW'(cfg.shift_outer) : IW'(cfg.shift_inner);

  // Next-state and datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    uns_nxt   = uns_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt     = IW'(in_ch.pos_x);
          y_nxt     = IW'(in_ch.pos_y);
          z_nxt     = IW'(in_ch.pos_z);
          vx_nxt    = in_ch.vel_x;
          vy_nxt    = in_ch.vel_y;
          last_nxt  = in_ch.last_in_batch;
          rem_nxt   = 1'b0;
          uns_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = (cfg.mode == psbw_pkg::MODE_NONE) ? ST_DONE : ST_X;
        end
      end
      ST_X, ST_Y, ST_Z: begin
        if (go_next) begin
          if (cfg.mode == psbw_pkg::MODE_OPEN) begin
            rem_nxt = rem_r | outside;
          end else begin
            uns_nxt = uns_r | outside;
          end
          cnt_nxt = '0;
          case (state_r)
            ST_X:    state_nxt = ST_Y;
            ST_Y:    state_nxt = ST_Z;
            default: state_nxt = ST_DONE;
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          case (state_r)
            ST_X:    x_nxt = alu_rsp.wrapped;
            ST_Y:    y_nxt = alu_rsp.wrapped;
            default: z_nxt = alu_rsp.wrapped;
          endcase
          // Radial wrap in shear mode also shifts y and kicks velocity
          if (shear_x) begin
            y_nxt  = y_r + shift_sel;
            vy_nxt = psbw_pkg::sat_addsub(vy_r, cfg.kick_az, alu_rsp.below);
            vx_nxt = psbw_pkg::sat_addsub(vx_r, cfg.kick_rad, alu_rsp.above);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    last_r <= last_nxt;
    rem_r  <= rem_nxt;
    uns_r  <= uns_nxt;
  end

  // Result payload, saturated to the coordinate range
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      ox_r    <= psbw_pkg::sat_coord(x_r);
      oy_r    <= psbw_pkg::sat_coord(y_r);
      oz_r    <= psbw_pkg::sat_coord(z_r);
      ovx_r   <= vx_r;
      ovy_r   <= vy_r;
      orem_r  <= rem_r;
      ouns_r  <= uns_r;
      olast_r <= last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.new_x          = ox_r;
  assign out_ch.new_y          = oy_r;
  assign out_ch.new_z          = oz_r;
  assign out_ch.new_vx         = ovx_r;
  assign out_ch.new_vy         = ovy_r;
  assign out_ch.remove_flag    = orem_r;
  assign out_ch.unsettled_flag = ouns_r;
  assign out_ch.last_out       = olast_r;

endmodule

[tb/sv/psbw_checker.sv]
// ----------------------------------------------------------------------------
// psbw_checker
// Watches the particle, result and register channels of the boundary wrap
// block. It keeps its own copy of the registers, works out the wrapped
// particle for every accepted input transaction and compares each result
// transaction, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psbw_checker
  import psbw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  psbw_in_if   in_ch,
  psbw_out_if  out_ch,
  psbw_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count
);

  localparam longint COORD_HI  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO  = -COORD_HI - 1;
  localparam int     MAX_LINES = 200;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic                          remove;
    logic                          unsettled;
    logic                          last;
  } wrap_result_t;

  // Register copy
  logic [MODE_W-1:0] bnd_mode;
  longint            box_len [3];
  longint            shift_outer;
  longint            shift_inner;
  longint            kick_az;
  longint            kick_rad;

  wrap_result_t      expected_q [$];
  int                mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Outside when 2c > box or 2c < -box
  function automatic bit beyond_half(input longint c, input longint box);
    return (2 * c > box) || (2 * c < -box);
  endfunction

  // Up to MAX_WRAPS passes on one axis; returns 1 if still outside
  function automatic bit settle_axis(inout longint c, input longint box);
    int n;
    for (n = 0; n < MAX_WRAPS; n++) begin
      if (2 * c > box) c -= box;
      else if (2 * c < -box) c += box;
      else break;
    end
    return beyond_half(c, box);
  endfunction

  // Expected wrapped particle under the current register copy
  function automatic wrap_result_t predict_wrap(input longint px, input longint py,
                                                input longint pz, input longint pvx,
                                                input longint pvy, input logic last_in);
    wrap_result_t r;
    longint       x, y, z, vx, vy;
    bit           drop, unset;
    int           n;
    x = px;
    y = py;
    z = pz;
    vx = pvx;
    vy = pvy;
    drop = 1'b0;
    unset = 1'b0;
    case (bnd_mode)
      MODE_OPEN: begin
        drop = beyond_half(x, box_len[0]) || beyond_half(y, box_len[1]) ||
               beyond_half(z, box_len[2]);
      end
      MODE_PERIODIC: begin
        if (settle_axis(x, box_len[0])) unset = 1'b1;
        if (settle_axis(y, box_len[1])) unset = 1'b1;
        if (settle_axis(z, box_len[2])) unset = 1'b1;
      end
      MODE_SHEAR: begin
        // radial wraps carry the y shift and both kicks
        for (n = 0; n < MAX_WRAPS; n++) begin
          if (2 * x > box_len[0]) begin
            x -= box_len[0];
            y += shift_outer;
            vy = clamp_coord(vy + kick_az);
            vx = clamp_coord(vx - kick_rad);
          end else if (2 * x < -box_len[0]) begin
            x += box_len[0];
            y += shift_inner;
            vy = clamp_coord(vy - kick_az);
            vx = clamp_coord(vx + kick_rad);
          end else begin
            break;
          end
        end
        if (beyond_half(x, box_len[0])) unset = 1'b1;
        if (settle_axis(y, box_len[1])) unset = 1'b1;
        if (settle_axis(z, box_len[2])) unset = 1'b1;
      end
      default: ;
    endcase
    r.x         = COORD_WIDTH'(clamp_coord(x));
    r.y         = COORD_WIDTH'(clamp_coord(y));
    r.z         = COORD_WIDTH'(clamp_coord(z));
    r.vx        = COORD_WIDTH'(clamp_coord(vx));
    r.vy        = COORD_WIDTH'(clamp_coord(vy));
    r.remove    = drop;
    r.unsettled = unset;
    r.last      = last_in;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_total < MAX_LINES) begin
      $display("[%0t] psbw mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_total++;
  endtask

  task automatic compare_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Channel monitor: compare results, queue predictions, track register writes
  always @(posedge clk) begin : monitor
    wrap_result_t want;
    if (!rst_n) begin
      bnd_mode    = MODE_NONE;
      box_len[0]  = longint'(BOX_RESET);
      box_len[1]  = longint'(BOX_RESET);
      box_len[2]  = longint'(BOX_RESET);
      shift_outer = 0;
      shift_inner = 0;
      kick_az     = 0;
      kick_rad    = 0;
      pending_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected", 0, 0);
        end else begin
          want = expected_q.pop_front();
          compare_field("new_x", longint'(out_ch.new_x), longint'(want.x));
          compare_field("new_y", longint'(out_ch.new_y), longint'(want.y));
          compare_field("new_z", longint'(out_ch.new_z), longint'(want.z));
          compare_field("new_vx", longint'(out_ch.new_vx), longint'(want.vx));
          compare_field("new_vy", longint'(out_ch.new_vy), longint'(want.vy));
          compare_field("remove_flag", longint'(out_ch.remove_flag), longint'(want.remove));
          compare_field("unsettled_flag", longint'(out_ch.unsettled_flag),
                        longint'(want.unsettled));
          compare_field("last_out", longint'(out_ch.last_out), longint'(want.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_wrap(longint'(in_ch.pos_x), longint'(in_ch.pos_y),
                                          longint'(in_ch.pos_z), longint'(in_ch.vel_x),
                                          longint'(in_ch.vel_y), in_ch.last_in_batch));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.wr_index)
          REG_MODE:        bnd_mode    = cfg_ch.wr_data[MODE_W-1:0];
          REG_BOX_X:       box_len[0]  = longint'(cfg_ch.wr_data[BOX_W-1:0]);
          REG_BOX_Y:       box_len[1]  = longint'(cfg_ch.wr_data[BOX_W-1:0]);
          REG_BOX_Z:       box_len[2]  = longint'(cfg_ch.wr_data[BOX_W-1:0]);
          REG_SHIFT_OUTER: shift_outer = longint'(signed'(cfg_ch.wr_data));
          REG_SHIFT_INNER: shift_inner = longint'(signed'(cfg_ch.wr_data));
          REG_KICK_AZ:     kick_az     = longint'(signed'(cfg_ch.wr_data));
          REG_KICK_RAD:    kick_rad    = longint'(signed'(cfg_ch.wr_data));
          default: ;
        endcase
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the periodic shear boundary wrap block. A short
// directed part hits field extremes, every boundary mode, box edges, the
// wrap limit, a zero box and kick saturation; then randomized register
// settings with particles placed around the box edges, plus noise, under
// random idle bursts on both channels. The checker does all comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import psbw_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 83;

  localparam logic signed [COORD_WIDTH-1:0] COORD_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_WIDTH-1:0] COORD_BOTTOM = 32'sh8000_0000;
  localparam int                            UNIT         = 65536;
  localparam int                            BOX_TOP      = 32'h7FFF_FFFF;
  localparam logic [MODE_W-1:0] MODE_ORDER [4] = '{MODE_NONE, MODE_OPEN,
                                                   MODE_PERIODIC, MODE_SHEAR};

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic                          last;
  } particle_t;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     pending_count;
  bit     idle_on  = 1'b1;
  bit     hold_req = 1'b0;
  longint box_now [3];

  psbw_in_if  in_ch ();
  psbw_out_if out_ch ();
  psbw_cfg_if cfg_ch ();

  periodic_shear_boundary_wrap_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  psbw_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int run;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        run = LONG_HOLD;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        run = $urandom_range(1, 18);
      end else begin
        out_ch.ready <= 1'b1;
        run = idle_on ? $urandom_range(1, 24) : 1;
      end
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog: too long without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [COORD_WIDTH-1:0] to_coord(input longint v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_BOTTOM) return COORD_BOTTOM;
    return COORD_WIDTH'(v);
  endfunction

  // Coordinate around the box edges or within a few box lengths
  function automatic logic signed [COORD_WIDTH-1:0] place_coord(input longint box);
    longint    reach;
    bit [63:0] u;
    u = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return to_coord(box / 2 + int'($urandom_range(0, 1)));
      1: return to_coord(-(box / 2) - int'($urandom_range(0, 1)));
      2: begin
        reach = box * int'($urandom_range(1, MAX_WRAPS + 1));
        return to_coord(u[0] ? reach : -reach);
      end
      default: begin
        reach = box * int'($urandom_range(1, MAX_WRAPS + 2)) / 2 + 1;
        return to_coord(longint'(u % (2 * reach + 1)) - reach);
      end
    endcase
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] pick_velocity();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return COORD_WIDTH'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      2: return COORD_TOP - $urandom_range(0, 1 << 16);
      default: return COORD_BOTTOM + $urandom_range(0, 1 << 16);
    endcase
  endfunction

  function automatic int pick_box();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return BOX_TOP;
      2: return int'($urandom_range(2, 64));
      3, 4: return int'($urandom_range(1 << 14, 1 << 20));
      5: return int'($urandom_range(1 << 20, 1 << 28));
      6: return int'($urandom & 32'h7FFF_FFFF);
      default: return UNIT;
    endcase
  endfunction

  // Shift or kick register value
  function automatic logic [CFG_DATA_W-1:0] shear_term();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return COORD_TOP;
      2: return COORD_BOTTOM;
      3, 4: return $urandom_range(0, 1 << 18) - (1 << 17);
      default: return $urandom;
    endcase
  endfunction

  // Mostly particles near the box, some full-range noise
  function automatic particle_t make_particle();
    particle_t p;
    if ($urandom_range(0, 9) == 0) begin
      p.x  = $urandom;
      p.y  = $urandom;
      p.z  = $urandom;
      p.vx = $urandom;
      p.vy = $urandom;
    end else begin
      p.x  = place_coord(box_now[0]);
      p.y  = place_coord(box_now[1]);
      p.z  = place_coord(box_now[2]);
      p.vx = pick_velocity();
      p.vy = pick_velocity();
    end
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  // One input transaction; valid stays high afterwards for back-to-back items
  task automatic send_particle(input particle_t p);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.pos_x         <= p.x;
    in_ch.pos_y         <= p.y;
    in_ch.pos_z         <= p.z;
    in_ch.vel_x         <= p.vx;
    in_ch.vel_y         <= p.vy;
    in_ch.last_in_batch <= p.last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Register write; valid is lowered by the caller after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.wr_index <= idx;
    cfg_ch.wr_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Full register set, written once the block has drained
  task automatic program_regs(input logic [MODE_W-1:0] mode, input int bx,
                              input int by, input int bz,
                              input logic [CFG_DATA_W-1:0] s_out,
                              input logic [CFG_DATA_W-1:0] s_in,
                              input logic [CFG_DATA_W-1:0] k_az,
                              input logic [CFG_DATA_W-1:0] k_rad);
    wait_drained();
    write_reg(REG_MODE, {$urandom} & ~32'(3) | 32'(mode));
    // upper bit of the box data is don't-care
    write_reg(REG_BOX_X, {1'($urandom), 31'(bx)});
    write_reg(REG_BOX_Y, {1'($urandom), 31'(by)});
    write_reg(REG_BOX_Z, {1'($urandom), 31'(bz)});
    write_reg(REG_SHIFT_OUTER, s_out);
    write_reg(REG_SHIFT_INNER, s_in);
    write_reg(REG_KICK_AZ, k_az);
    write_reg(REG_KICK_RAD, k_rad);
    cfg_ch.valid <= 1'b0;
    box_now[0] = longint'(bx);
    box_now[1] = longint'(by);
    box_now[2] = longint'(bz);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [MODE_W-1:0] mode;
    in_ch.valid         <= 1'b0;
    in_ch.pos_x         <= '0;
    in_ch.pos_y         <= '0;
    in_ch.pos_z         <= '0;
    in_ch.vel_x         <= '0;
    in_ch.vel_y         <= '0;
    in_ch.last_in_batch <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.wr_index     <= '0;
    cfg_ch.wr_data      <= '0;
    rst_n               <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through, field extremes
    program_regs(MODE_NONE, UNIT, UNIT, UNIT, '0, '0, '0, '0);
    send_particle('{COORD_BOTTOM, COORD_TOP, 0, COORD_BOTTOM, COORD_TOP, 1'b1});
    send_particle('{COORD_TOP, COORD_BOTTOM, -1, COORD_TOP, COORD_BOTTOM, 1'b0});
    send_particle('{32'sh1234_5678, 32'shEDCB_A987, 32'sh5555_5555, 32'shAAAA_AAAA,
                    32'sh0F0F_F0F0, 1'b1});

    // open boundary: exact half-box is inside, one step past is removed
    program_regs(MODE_OPEN, UNIT, 2 * UNIT, 1, '0, '0, '0, '0);
    send_particle('{0, 0, 0, 0, 0, 1'b0});
    send_particle('{UNIT / 2, -UNIT, 0, 7, -7, 1'b0});
    send_particle('{UNIT / 2 + 1, 0, 0, 0, 0, 1'b0});
    send_particle('{0, -UNIT - 1, 0, 0, 0, 1'b0});
    send_particle('{-UNIT / 2, UNIT, 1, 0, 0, 1'b0});
    send_particle('{-UNIT / 2 - 1, 0, -1, 0, 0, 1'b1});

    // periodic: wrap limit reached exactly, limit exceeded, full-scale box
    program_regs(MODE_PERIODIC, UNIT, 3 * UNIT, BOX_TOP, '0, '0, '0, '0);
    send_particle('{8 * UNIT, 0, COORD_TOP, 0, 0, 1'b0});
    send_particle('{8 * UNIT + UNIT / 2 + 1, 0, COORD_BOTTOM, 0, 0, 1'b0});
    send_particle('{COORD_BOTTOM, COORD_TOP, 0, 1, 1, 1'b0});
    send_particle('{-UNIT / 2, 3 * UNIT / 2, -3 * UNIT / 2 - 1, 0, 0, 1'b1});

    // zero box: outside coordinate stays put and is flagged
    program_regs(MODE_PERIODIC, 0, 1, UNIT, '0, '0, '0, '0);
    send_particle('{0, 1, 0, 0, 0, 1'b0});
    send_particle('{5, -1, UNIT, 0, 0, 1'b1});

    // shear with extreme shifts and kicks: y and velocities saturate
    program_regs(MODE_SHEAR, UNIT, BOX_TOP, UNIT, COORD_TOP, COORD_BOTTOM,
                 COORD_TOP, COORD_BOTTOM);
    send_particle('{3 * UNIT, 0, 0, COORD_BOTTOM, COORD_TOP, 1'b0});
    send_particle('{-9 * UNIT, COORD_BOTTOM, 0, COORD_TOP, COORD_BOTTOM, 1'b0});
    send_particle('{UNIT / 4, 5, 7, 100, -100, 1'b1});

    // shear with moderate terms, one wrap each side
    program_regs(MODE_SHEAR, 2 * UNIT, 2 * UNIT, 2 * UNIT, UNIT / 3, -UNIT / 3, 1000, -2000);
    send_particle('{UNIT + 1, UNIT, -UNIT - 1, 50, 60, 1'b0});
    send_particle('{-UNIT - 5, -UNIT, UNIT + 1, -50, -60, 1'b1});

    // random register settings and particles
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      mode = (ph < 8) ? MODE_ORDER[ph % 4] : MODE_ORDER[$urandom_range(0, 3)];
      program_regs(mode, pick_box(), pick_box(), pick_box(), shear_term(), shear_term(),
                   shear_term(), shear_term());
      // long result-side hold-off while particles keep coming
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained();
        send_particle(make_particle());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
